### rtl/core/tpd_pkg.sv
package tpd_pkg;

    localparam int SAMPLE_W = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PLANES = 4;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_HORIZ = 2'd1,
        MODE_FLOAT = 2'd2,
        MODE_UNSUP = 2'd3
    } mode_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_DRAIN  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_UNSUPP = 2'd2,
        STATUS_BUSY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MODE        = 2'd0,
        REG_SAMPLE_BITS = 2'd1,
        REG_CHANNELS    = 2'd2,
        REG_ROW_WIDTH   = 2'd3
    } cfg_reg_t;

    localparam logic [1:0] SB_8 = 2'd0;
    localparam logic [1:0] SB_16 = 2'd1;

endpackage

### rtl/core/tiff_predictor_decoder_top.sv
// a result passes through the s1 register and then the output register before it is shown
// throughput: one input transaction per cycle while the output is not stalled, floating bytes and samples alike
// drain words come from four byte-plane banks read together, one word per request
// reset: registers return to mode none, 8 bit, one channel, width one; counters clear
// the line store is not cleared and holds nothing until a row is written
module tiff_predictor_decoder_top
    import tpd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,  // sample
    input  logic                  s_tuser,  // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,  // value
    output logic [STATUS_W-1:0]   m_tuser,  // status
    output logic                  m_tlast
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);

    mode_t                 mode_reg, mode_next;
    logic [1:0]            sample_bits_reg, sample_bits_next;
    logic [3:0]            channels_reg, channels_next;
    logic [CFG_DATA_W-1:0] row_width_reg, row_width_next;

    logic [SAMPLE_W-1:0] prev_reg [MAX_CHANNELS];
    logic [IW-1:0]       chan_reg, chan_next;
    logic [AW-1:0]       col_reg, col_next;
    logic [7:0]          byte_sum_reg, byte_sum_next;
    logic [1:0]          plane_reg, plane_next;
    logic [AW-1:0]       byte_col_reg, byte_col_next;
    logic [AW-1:0]       drain_reg, drain_next;
    logic                row_ready_reg, row_ready_next;

    logic [7:0] line_store_mem [PLANES][MAX_WIDTH];
    logic [7:0] rd_data_reg [PLANES];

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_drain_reg;
    logic [SAMPLE_W-1:0] s1_value_reg;
    status_t             s1_status_reg;
    logic                s1_last_reg;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_value_reg;
    status_t             out_status_reg;
    logic                out_last_reg;

    logic                accept;
    logic                out_free;
    logic [EW-1:0]       eff_w;
    logic [CW-1:0]       eff_ch;
    logic                chan_wrap, col_wrap, byte_col_wrap;
    logic [SAMPLE_W-1:0] mask;
    logic [SAMPLE_W-1:0] hz_value;
    logic [7:0]          byte_in, sum;

    logic                res_valid, res_drain, res_last;
    logic [SAMPLE_W-1:0] res_value;
    status_t             res_status;
    logic                prev_we, mem_we, rd_en;

    always_comb
    begin
        if (row_width_reg == '0)
            eff_w = EW'(1);
        else if (32'(row_width_reg) > 32'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(row_width_reg);

        if (channels_reg == '0)
            eff_ch = CW'(1);
        else if (32'(channels_reg) > 32'(MAX_CHANNELS))
            eff_ch = CW'(MAX_CHANNELS);
        else
            eff_ch = CW'(channels_reg);

        case (sample_bits_reg)
            SB_8:    mask = 32'h0000_00FF;
            SB_16:   mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    assign chan_wrap = (chan_reg == IW'(eff_ch - CW'(1)));
    assign col_wrap = (col_reg == AW'(eff_w - EW'(1)));
    assign byte_col_wrap = (byte_col_reg == AW'(eff_w - EW'(1)));

    assign hz_value = (col_reg != '0) ? ((s_tdata & mask) + prev_reg[chan_reg]) & mask
                                      : (s_tdata & mask);
    assign byte_in = s_tdata[7:0];
    assign sum = (plane_reg == '0 && byte_col_reg == '0) ? byte_in : byte_sum_reg + byte_in;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        mode_next = mode_reg;
        sample_bits_next = sample_bits_reg;
        channels_next = channels_reg;
        row_width_next = row_width_reg;
        chan_next = chan_reg;
        col_next = col_reg;
        byte_sum_next = byte_sum_reg;
        plane_next = plane_reg;
        byte_col_next = byte_col_reg;
        drain_next = drain_reg;
        row_ready_next = row_ready_reg;
        res_valid = 1'b0;
        res_drain = 1'b0;
        res_last = 1'b0;
        res_value = '0;
        res_status = STATUS_OK;
        prev_we = 1'b0;
        mem_we = 1'b0;
        rd_en = 1'b0;

        if (accept)
        begin
            if (mode_reg == MODE_UNSUP)
            begin
                res_valid = 1'b1;
                res_status = STATUS_UNSUPP;
            end
            else if (s_tuser == REQ_DRAIN)
            begin
                res_valid = 1'b1;
                if (mode_reg == MODE_FLOAT && row_ready_reg)
                begin
                    res_drain = 1'b1;
                    rd_en = 1'b1;
                    if (drain_reg == AW'(eff_w - EW'(1)))
                    begin
                        res_last = 1'b1;
                        row_ready_next = 1'b0;
                        drain_next = '0;
                    end
                    else
                    begin
                        drain_next = drain_reg + AW'(1);
                    end
                end
                else
                begin
                    res_status = STATUS_EMPTY;
                end
            end
            else if (mode_reg == MODE_FLOAT)
            begin
                if (row_ready_reg)
                begin
                    res_valid = 1'b1;
                    res_status = STATUS_BUSY;
                end
                else
                begin
                    mem_we = 1'b1;
                    byte_sum_next = sum;
                    if (byte_col_wrap)
                    begin
                        byte_col_next = '0;
                        if (plane_reg == 2'(PLANES - 1))
                        begin
                            plane_next = '0;
                            row_ready_next = 1'b1;
                            drain_next = '0;
                        end
                        else
                        begin
                            plane_next = plane_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        byte_col_next = byte_col_reg + AW'(1);
                    end
                end
            end
            else
            begin
                res_valid = 1'b1;
                res_last = chan_wrap && col_wrap;
                if (mode_reg == MODE_HORIZ)
                begin
                    res_value = hz_value;
                    prev_we = 1'b1;
                end
                else
                begin
                    res_value = s_tdata;
                end
                if (chan_wrap)
                begin
                    chan_next = '0;
                    col_next = col_wrap ? '0 : col_reg + AW'(1);
                end
                else
                begin
                    chan_next = chan_reg + IW'(1);
                end
            end
        end

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:        mode_next = mode_t'(cfg_data[1:0]);
                REG_SAMPLE_BITS: sample_bits_next = cfg_data[1:0];
                REG_CHANNELS:    channels_next = cfg_data[3:0];
                REG_ROW_WIDTH:   row_width_next = cfg_data;
                default:         mode_next = mode_reg;
            endcase
            chan_next = '0;
            col_next = '0;
            byte_sum_next = '0;
            plane_next = '0;
            byte_col_next = '0;
            drain_next = '0;
            row_ready_next = 1'b0;
        end
    end

    assign s1_valid_next = s_tready ? res_valid : s1_valid_reg;
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            sample_bits_reg <= SB_8;
            channels_reg <= 4'd1;
            row_width_reg <= CFG_DATA_W'(1);
            chan_reg <= '0;
            col_reg <= '0;
            byte_sum_reg <= '0;
            plane_reg <= '0;
            byte_col_reg <= '0;
            drain_reg <= '0;
            row_ready_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                prev_reg[i] <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            sample_bits_reg <= sample_bits_next;
            channels_reg <= channels_next;
            row_width_reg <= row_width_next;
            chan_reg <= chan_next;
            col_reg <= col_next;
            byte_sum_reg <= byte_sum_next;
            plane_reg <= plane_next;
            byte_col_reg <= byte_col_next;
            drain_reg <= drain_next;
            row_ready_reg <= row_ready_next;
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (prev_we)
                prev_reg[chan_reg] <= hz_value;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            s1_drain_reg <= res_drain;
            s1_value_reg <= res_value;
            s1_status_reg <= res_status;
            s1_last_reg <= res_last;
        end
        if (out_free && s1_valid_reg)
        begin
            out_value_reg <= s1_drain_reg ? {rd_data_reg[0], rd_data_reg[1],
                                             rd_data_reg[2], rd_data_reg[3]}
                                          : s1_value_reg;
            out_status_reg <= s1_status_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    // byte-plane banks of the line store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_store_mem[plane_reg][byte_col_reg] <= sum;
        if (rd_en)
        begin
            for (int k = 0; k < PLANES; k++)
                rd_data_reg[k] <= line_store_mem[k][drain_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_value_reg;
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

endmodule

### rtl/core/tpd_checker.sv
module tpd_checker
    import tpd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tlast
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result transaction changed");

    // end of row only on a good result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == STATUS_OK)
        else $error("row end flagged on an error result");

    // error results carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0 && !m_tlast)
        else $error("error result with non-zero value");

    // an accepted drain always answers through s1 and the output register when the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == REQ_DRAIN) ##1 m_tready |=> m_tvalid)
        else $error("drain request gave no result");

endmodule

bind tiff_predictor_decoder_top tpd_checker u_tpd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### test/testbench.sv
module testbench;
    import tpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 20;
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_CHANNELS = 8;
    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        status_t             status;
        logic                last;
    } outcome_t;

    typedef struct {
        bit                    is_write;
        cfg_reg_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        req_t                  req;
        logic [SAMPLE_W-1:0]   word;
        bit                    typed;
        outcome_t              result;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;  // sample
    logic                  s_tuser = 1'b0;  // req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;  // value
    logic [STATUS_W-1:0]   m_tuser;  // status
    logic                  m_tlast;

    // predictor state
    mode_t                 reg_mode = MODE_NONE;
    logic [1:0]            reg_sample_bits = SB_8;
    logic [3:0]            reg_channels = 4'd1;
    logic [12:0]           reg_row_width = 13'd1;
    logic [31:0]           prev_sample [MAX_CHANNELS];
    logic [7:0]            line_store [4*MAX_WIDTH];
    int                    chan_idx = 0;
    int                    column = 0;
    logic [7:0]            byte_sum = '0;
    int                    byte_pos = 0;
    int                    drain_pos = 0;
    bit                    row_ready = 1'b0;

    outcome_t              predicted_words [$];
    outcome_t              head;
    script_row_t           script [$];
    int                    failures = 0;
    int                    items_sent = 0;
    int                    ready_hold = 0;
    int                    quiet_cycles = 0;
    bit                    calm = 1'b0;
    bit                    steady = 1'b0;

    tiff_predictor_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int active_width();
        if (reg_row_width == 0) return 1;
        if (reg_row_width > MAX_WIDTH) return MAX_WIDTH;
        return reg_row_width;
    endfunction

    function automatic int active_channels();
        if (reg_channels == 0) return 1;
        if (reg_channels > MAX_CHANNELS) return MAX_CHANNELS;
        return reg_channels;
    endfunction

    function automatic void apply_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:        reg_mode = mode_t'(data[1:0]);
            REG_SAMPLE_BITS: reg_sample_bits = data[1:0];
            REG_CHANNELS:    reg_channels = data[3:0];
            REG_ROW_WIDTH:   reg_row_width = data;
            default:         ;
        endcase
        chan_idx = 0;
        column = 0;
        byte_sum = '0;
        byte_pos = 0;
        drain_pos = 0;
        row_ready = 1'b0;
    endfunction

    // moves to the next channel or pixel, true on the last sample of the row
    function automatic bit step_pixel();
        bit pixel_done;
        bit row_done;
        pixel_done = (chan_idx + 1 >= active_channels());
        row_done = pixel_done && (column + 1 >= active_width());
        if (pixel_done)
        begin
            chan_idx = 0;
            column = (column + 1 >= active_width()) ? 0 : column + 1;
        end
        else
        begin
            chan_idx++;
        end
        return row_done;
    endfunction

    function automatic bit undo_prediction(input req_t req, input logic [31:0] word,
                                           output outcome_t res);
        int w;
        logic [31:0] mask;
        logic [31:0] v;
        logic [7:0] nb;
        w = active_width();
        res.value = '0;
        res.status = STATUS_OK;
        res.last = 1'b0;
        if (reg_mode == MODE_UNSUP)
        begin
            res.status = STATUS_UNSUPP;
        end
        else if (req == REQ_DRAIN)
        begin
            if (reg_mode == MODE_FLOAT && row_ready && drain_pos < w)
            begin
                res.value = {line_store[drain_pos], line_store[w + drain_pos],
                             line_store[2*w + drain_pos], line_store[3*w + drain_pos]};
                drain_pos++;
                if (drain_pos >= w)
                begin
                    res.last = 1'b1;
                    row_ready = 1'b0;
                    drain_pos = 0;
                end
            end
            else
            begin
                res.status = STATUS_EMPTY;
            end
        end
        else if (reg_mode == MODE_NONE)
        begin
            res.value = word;
            res.last = step_pixel();
        end
        else if (reg_mode == MODE_HORIZ)
        begin
            mask = (reg_sample_bits == SB_8) ? 32'h0000_00FF :
                   (reg_sample_bits == SB_16) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
            v = word & mask;
            if (column != 0)
                v = (v + prev_sample[chan_idx]) & mask;
            prev_sample[chan_idx] = v;
            res.value = v;
            res.last = step_pixel();
        end
        else if (row_ready)
        begin
            res.status = STATUS_BUSY;
        end
        else
        begin
            nb = (byte_pos == 0) ? word[7:0] : byte_sum + word[7:0];
            line_store[byte_pos] = nb;
            byte_sum = nb;
            byte_pos++;
            if (byte_pos >= 4 * w)
            begin
                byte_pos = 0;
                drain_pos = 0;
                row_ready = 1'b1;
            end
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic script_row_t reg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        script_row_t r;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic script_row_t item_row(input req_t req, input logic [31:0] word);
        script_row_t r;
        r.is_write = 1'b0;
        r.req = req;
        r.word = word;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic script_row_t checked_row(input req_t req, input logic [31:0] word,
                                                input logic [31:0] value, input status_t st,
                                                input bit last);
        script_row_t r;
        r = item_row(req, word);
        r.typed = 1'b1;
        r.result.value = value;
        r.result.status = st;
        r.result.last = last;
        return r;
    endfunction

    task automatic settle();
        s_tvalid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        apply_register(idx, data);
    endtask

    task automatic send_item(input req_t req, input logic [31:0] word, input bit typed,
                             input outcome_t typed_result);
        outcome_t guess;
        bit has_result;
        cfg_we <= 1'b0;
        if (!calm && !steady && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        has_result = undo_prediction(req, word, guess);
        if (typed)
            predicted_words.push_back(typed_result);
        else if (has_result)
            predicted_words.push_back(guess);
        items_sent++;
    endtask

    task automatic random_phase();
        mode_t m;
        int pick;
        int w;
        int ch;
        int n;
        pick = $urandom_range(0, 9);
        m = (pick < 2) ? MODE_NONE : (pick < 6) ? MODE_HORIZ :
            (pick < 9) ? MODE_FLOAT : MODE_UNSUP;
        pick = $urandom_range(0, 15);
        w = (pick == 0) ? 0 : (pick == 1) ? MAX_WIDTH : (pick == 2) ? 8191 :
            (pick == 3) ? $urandom_range(1, 8191) : $urandom_range(1, 6);
        pick = $urandom_range(0, 9);
        ch = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(9, 15) :
             (pick == 2) ? MAX_CHANNELS : $urandom_range(1, 4);
        steady = ($urandom_range(0, 3) == 0);
        settle();
        write_register(REG_MODE, {11'($urandom), 2'(m)});
        if ($urandom_range(0, 3) != 0)
            write_register(REG_SAMPLE_BITS, {11'($urandom), 2'($urandom_range(0, 3))});
        if ($urandom_range(0, 3) != 0)
            write_register(REG_CHANNELS, {9'($urandom), 4'(ch)});
        if ($urandom_range(0, 3) != 0)
            write_register(REG_ROW_WIDTH, 13'(w));
        w = active_width();
        ch = active_channels();
        case (m)
            MODE_FLOAT:
            begin
                if (w <= 16)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        for (int b = 0; b < 4 * w; b++)
                        begin
                            if ($urandom_range(0, 19) == 0)
                                send_item(REQ_DRAIN, random_word(), 1'b0, '0);
                            send_item(REQ_SAMPLE, random_word(), 1'b0, '0);
                        end
                        for (int d = 0; d < w; d++)
                        begin
                            if ($urandom_range(0, 19) == 0)
                                send_item(REQ_SAMPLE, random_word(), 1'b0, '0);
                            send_item(REQ_DRAIN, random_word(), 1'b0, '0);
                        end
                        if ($urandom_range(0, 3) == 0)
                            send_item(REQ_DRAIN, random_word(), 1'b0, '0);
                    end
                end
                else
                begin
                    repeat (48)
                        send_item(req_t'($urandom_range(0, 4) == 0), random_word(), 1'b0, '0);
                end
            end
            MODE_UNSUP:
            begin
                repeat (12)
                    send_item(req_t'($urandom_range(0, 1)), random_word(), 1'b0, '0);
            end
            default:
            begin
                n = w * ch * $urandom_range(1, 3);
                if (n > 150)
                    n = 150;
                repeat (n)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(REQ_DRAIN, random_word(), 1'b0, '0);
                    send_item(REQ_SAMPLE, random_word(), 1'b0, '0);
                end
            end
        endcase
    endtask

    // result stall bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && !steady && $urandom_range(0, 7) == 0)
        begin
            ready_hold <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_words.size() == 0)
            begin
                $error("unexpected transaction: value %h status %0d last %0d",
                       m_tdata, m_tuser, m_tlast);
                failures++;
            end
            else
            begin
                head = predicted_words.pop_front();
                if (m_tdata !== head.value)
                begin
                    $error("value: expected %h, got %h", head.value, m_tdata);
                    failures++;
                end
                if (m_tuser !== head.status)
                begin
                    $error("status: expected %0d, got %0d", head.status, m_tuser);
                    failures++;
                end
                if (m_tlast !== head.last)
                begin
                    $error("last_of_row: expected %0d, got %0d", head.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        bit after_write;
        int total_items;
        after_write = 1'b0;
        foreach (prev_sample[i])
            prev_sample[i] = '0;

        // reset state: mode none, one pixel per row
        script.push_back(checked_row(REQ_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STATUS_OK, 1'b1));
        script.push_back(checked_row(REQ_SAMPLE, 32'h0000_0000, 32'h0000_0000, STATUS_OK, 1'b1));
        script.push_back(checked_row(REQ_DRAIN, 32'h0000_0000, 32'h0, STATUS_EMPTY, 1'b0));
        script.push_back(reg_row(REG_MODE, 13'(MODE_UNSUP)));
        script.push_back(checked_row(REQ_SAMPLE, 32'h1234_5678, 32'h0, STATUS_UNSUPP, 1'b0));
        script.push_back(checked_row(REQ_DRAIN, 32'h0000_0000, 32'h0, STATUS_UNSUPP, 1'b0));
        // horizontal, 8 bit, wrap and masking of high bits
        script.push_back(reg_row(REG_MODE, 13'(MODE_HORIZ)));
        script.push_back(reg_row(REG_SAMPLE_BITS, 13'(SB_8)));
        script.push_back(reg_row(REG_CHANNELS, 13'd1));
        script.push_back(reg_row(REG_ROW_WIDTH, 13'd2));
        script.push_back(checked_row(REQ_SAMPLE, 32'hABCD_EF80, 32'h0000_0080, STATUS_OK, 1'b0));
        script.push_back(checked_row(REQ_SAMPLE, 32'h0000_00FF, 32'h0000_007F, STATUS_OK, 1'b1));
        // width code 3 behaves as 32 bit
        script.push_back(reg_row(REG_SAMPLE_BITS, 13'd3));
        script.push_back(checked_row(REQ_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STATUS_OK, 1'b0));
        script.push_back(checked_row(REQ_SAMPLE, 32'h0000_0002, 32'h0000_0001, STATUS_OK, 1'b1));
        // zero channels, then saturated channels and width
        script.push_back(reg_row(REG_SAMPLE_BITS, 13'(SB_16)));
        script.push_back(reg_row(REG_CHANNELS, 13'd0));
        script.push_back(item_row(REQ_SAMPLE, 32'h1234_FFFF));
        script.push_back(item_row(REQ_SAMPLE, 32'h0000_0002));
        script.push_back(reg_row(REG_CHANNELS, 13'd15));
        script.push_back(reg_row(REG_ROW_WIDTH, 13'h1FFF));
        script.push_back(item_row(REQ_SAMPLE, 32'h8000_0000));
        script.push_back(item_row(REQ_SAMPLE, 32'h7FFF_FFFF));
        // floating point with zero width: one word, busy and empty drains
        script.push_back(reg_row(REG_MODE, 13'(MODE_FLOAT)));
        script.push_back(reg_row(REG_ROW_WIDTH, 13'd0));
        script.push_back(checked_row(REQ_DRAIN, 32'h0000_0000, 32'h0, STATUS_EMPTY, 1'b0));
        script.push_back(item_row(REQ_SAMPLE, 32'h0000_0001));
        script.push_back(item_row(REQ_SAMPLE, 32'h0000_0102));
        script.push_back(item_row(REQ_SAMPLE, 32'h0000_0003));
        script.push_back(item_row(REQ_SAMPLE, 32'hFFFF_FF04));
        script.push_back(checked_row(REQ_SAMPLE, 32'h0000_0055, 32'h0, STATUS_BUSY, 1'b0));
        script.push_back(checked_row(REQ_DRAIN, 32'h0000_0000, 32'h0103_060A, STATUS_OK, 1'b1));
        script.push_back(checked_row(REQ_DRAIN, 32'h0000_0000, 32'h0, STATUS_EMPTY, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                if (!after_write)
                    settle();
                write_register(script[i].reg_idx, script[i].reg_val);
                after_write = 1'b1;
            end
            else
            begin
                send_item(script[i].req, script[i].word, script[i].typed, script[i].result);
                after_write = 1'b0;
            end
        end

        total_items = items_sent + RANDOM_ITEMS;
        while (items_sent < total_items)
        begin
            calm = (items_sent >= total_items - CALM_ITEMS);
            random_phase();
        end

        s_tvalid <= 1'b0;
        cfg_we <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (failures == 0 && predicted_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
